/* hdl/mddm_pkg.sv */
`timescale 1ns / 1ps

package mddm_pkg;

    localparam int NUM_CH     = 7;
    localparam int FIRST_REAR = 5;
    localparam int CH_W       = 3;

    localparam int SAMPLE_W   = 24;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int GAIN_W     = 17;
    localparam int DLONG_W    = 12;
    localparam int DSHORT_W   = 10;
    localparam int SHELF_W    = 15;
    localparam int ALPHA_W    = 16;

    localparam logic [SHELF_W-1:0] SHELF_RESET = 15'd8192;

    // Lowpass state carries 8 extra fraction bits below the sample LSB.
    localparam int EXT_BITS   = 8;
    localparam int LP_W       = 32;
    localparam int DIFF_W     = 33;
    localparam int SUM_W      = 36;
    localparam int PROD_W     = 54;
    localparam int MIX_W      = 31;

    localparam int ALPHA_SHIFT = 16;
    localparam int SHELF_SHIFT = 13;
    localparam int FRONT_SHIFT = 16;
    localparam int REAR_SHIFT  = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIFFUSION_GAIN = 3'd0,
        CFG_DELAY_LONG     = 3'd1,
        CFG_DELAY_SHORT    = 3'd2,
        CFG_SHELF_GAIN     = 3'd3,
        CFG_SHELF_ALPHA    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LONG,
        ST_CAP_LONG,
        ST_CAP_SHORT,
        ST_MUL_ALPHA,
        ST_LP_UPD,
        ST_MUL_SHELF,
        ST_SHELF,
        ST_MUL_GAIN,
        ST_MIX,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_GAIN,
        MUL_ALPHA,
        MUL_SHELF
    } t_mul_op;

    typedef struct packed {
        logic            idle;
        logic [CH_W-1:0] ch;
        logic            mem_wr;
        logic            rd_short;
        logic            cap_long;
        logic            cap_short;
        logic            mul_en;
        t_mul_op         mul_op;
        logic            lp_upd;
        logic            shelf_add;
        logic            mix;
        logic            finish;
    } t_ctrl;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_ch0;
        logic signed [SAMPLE_W-1:0] in_ch1;
        logic signed [SAMPLE_W-1:0] in_ch2;
        logic signed [SAMPLE_W-1:0] in_ch3;
        logic signed [SAMPLE_W-1:0] in_ch4;
        logic signed [SAMPLE_W-1:0] in_rear5;
        logic signed [SAMPLE_W-1:0] in_rear6;
        logic                       end_of_block;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_ch0;
        logic signed [SAMPLE_W-1:0] out_ch1;
        logic signed [SAMPLE_W-1:0] out_ch2;
        logic signed [SAMPLE_W-1:0] out_ch3;
        logic signed [SAMPLE_W-1:0] out_ch4;
        logic signed [SAMPLE_W-1:0] out_rear5;
        logic signed [SAMPLE_W-1:0] out_rear6;
        logic                       block_done;
    } t_out;

endpackage

/* hdl/mddm_ctrl.sv */
`timescale 1ns / 1ps

module mddm_ctrl
    import mddm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    output t_ctrl o_ctrl
);

    t_state          r_state;
    t_state          n_state;
    logic [CH_W-1:0] r_ch;
    logic [CH_W-1:0] n_ch;
    logic            rear;
    logic            last;

    assign rear = (r_ch >= CH_W'(FIRST_REAR));
    assign last = (r_ch == CH_W'(NUM_CH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RD_LONG;
                    n_ch    = '0;
                end
            end
            ST_RD_LONG:   n_state = ST_CAP_LONG;
            ST_CAP_LONG:  n_state = rear ? ST_CAP_SHORT : ST_MUL_GAIN;
            ST_CAP_SHORT: n_state = ST_MUL_ALPHA;
            ST_MUL_ALPHA: n_state = ST_LP_UPD;
            ST_LP_UPD:    n_state = ST_MUL_SHELF;
            ST_MUL_SHELF: n_state = ST_SHELF;
            ST_SHELF:     n_state = ST_MUL_GAIN;
            ST_MUL_GAIN:  n_state = ST_MIX;
            ST_MIX: begin
                if (last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD_LONG;
                    n_ch    = r_ch + CH_W'(1);
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.ch     = r_ch;
        o_ctrl.mul_op = MUL_GAIN;
        case (r_state)
            ST_IDLE:      o_ctrl.idle = 1'b1;
            ST_RD_LONG:   o_ctrl.mem_wr = 1'b1;
            ST_CAP_LONG: begin
                o_ctrl.cap_long = 1'b1;
                o_ctrl.rd_short = 1'b1;
            end
            ST_CAP_SHORT: o_ctrl.cap_short = 1'b1;
            ST_MUL_ALPHA: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = MUL_ALPHA;
            end
            ST_LP_UPD:    o_ctrl.lp_upd = 1'b1;
            ST_MUL_SHELF: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = MUL_SHELF;
            end
            ST_SHELF:     o_ctrl.shelf_add = 1'b1;
            ST_MUL_GAIN: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = MUL_GAIN;
            end
            ST_MIX:       o_ctrl.mix = 1'b1;
            ST_DONE:      o_ctrl.finish = 1'b1;
            default:      o_ctrl.idle = 1'b0;
        endcase
    end

endmodule

/* hdl/multichannel_delay_diffusion_mixer.sv */
`timescale 1ns / 1ps

// Seven-channel delay diffusion mixer.
// Input channel: one audio frame per transaction (i_in_valid / o_in_stall,
// payload i_in_data). Output channel: one mixed frame per transaction
// (o_out_valid / i_out_stall, payload o_out_data). Registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must write them only
// while no frame is in flight; the block itself does not enforce this.
// All seven delay lines share one single-port-write, single-port-read RAM
// with a registered read. Each channel takes a write plus a long tap read;
// the rear channels add a short tap read and a lowpass/shelf pass through
// the one shared multiplier. Channels are processed in turn, and the block
// takes a new frame only after the previous one is in the output register.
// Reset sets the shelf gain to 1.0, clears the other registers, lowpass
// state and the write position. Lines read as zero until their entry has
// been written since reset, tracked by the write position and a wrap flag,
// so no clearing pass is needed. If the receiver stalls, the finished frame
// stays in the output register and the next finished frame waits in the
// block until the register frees.
module multichannel_delay_diffusion_mixer
    import mddm_pkg::*;
#(
    parameter int MAX_DELAY = 4095
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int LINE_LEN  = MAX_DELAY + 1;
    localparam int PW        = $clog2(LINE_LEN);
    localparam int MEM_DEPTH = NUM_CH * (2 ** PW);
    localparam int AW        = $clog2(MEM_DEPTH);

    t_ctrl ctrl;
    logic  in_acc;
    logic  out_free;
    logic  out_load;
    logic  rear;

    logic [GAIN_W-1:0]   r_gain;
    logic [DLONG_W-1:0]  r_dlong;
    logic [DSHORT_W-1:0] r_dshort;
    logic [SHELF_W-1:0]  r_sg;
    logic [ALPHA_W-1:0]  r_alpha;

    logic [PW-1:0] r_pos;
    logic          r_full;
    logic [PW-1:0] dl_long;
    logic [PW-1:0] dl_short;
    logic [PW-1:0] ra;
    logic [PW-1:0] rb;
    logic [PW-1:0] r_ra;
    logic [PW-1:0] r_rb;
    logic          r_ra_fwd;
    logic          r_ra_ok;
    logic          r_rb_fwd;
    logic          r_rb_ok;

    t_in                        r_in;
    logic signed [SAMPLE_W-1:0] x_arr [NUM_CH];
    logic signed [SAMPLE_W-1:0] x_cur;

    logic [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;

    logic signed [SAMPLE_W-1:0] r_d;
    logic signed [SAMPLE_W-1:0] r_s;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [LP_W-1:0]     r_lp [2];
    logic                       lp_sel;
    logic signed [LP_W-1:0]     lp_cur;
    logic signed [LP_W-1:0]     d8;
    logic signed [LP_W-1:0]     s8;

    logic [GAIN_W-1:0]        mul_a;
    logic signed [SUM_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DIFF_W-1:0] lp_step;
    logic signed [SUM_W-1:0]  shelf_term;
    logic signed [MIX_W-1:0]  wet;
    logic signed [MIX_W-1:0]  mix_sum;
    logic [SAMPLE_W-1:0]      mix_sat;

    logic [SAMPLE_W-1:0] r_res [NUM_CH];
    logic                r_out_valid;
    t_out                r_out;

    function automatic logic [PW-1:0] tap_of(input logic [PW-1:0] pos,
                                             input logic [PW-1:0] dly);
        logic [PW:0] t;
        t = {1'b0, pos} - {1'b0, dly};
        if (t[PW]) begin
            t = t + (PW + 1)'(LINE_LEN);
        end
        return t[PW-1:0];
    endfunction

    mddm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    assign o_in_stall = !ctrl.idle;
    assign in_acc     = i_in_valid && ctrl.idle;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = ctrl.finish && out_free;
    assign rear       = (ctrl.ch >= CH_W'(FIRST_REAR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= '0;
            r_dlong  <= '0;
            r_dshort <= '0;
            r_sg     <= SHELF_RESET;
            r_alpha  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DIFFUSION_GAIN: r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DELAY_LONG:     r_dlong  <= i_cfg_wdata[DLONG_W-1:0];
                CFG_DELAY_SHORT:    r_dshort <= i_cfg_wdata[DSHORT_W-1:0];
                CFG_SHELF_GAIN:     r_sg     <= i_cfg_wdata[SHELF_W-1:0];
                CFG_SHELF_ALPHA:    r_alpha  <= i_cfg_wdata[ALPHA_W-1:0];
                default:            r_gain   <= r_gain;
            endcase
        end
    end

    // Tap addresses and their status are fixed for the whole frame.
    always_comb begin
        dl_long  = (32'(r_dlong) > 32'(MAX_DELAY)) ? PW'(MAX_DELAY) : PW'(r_dlong);
        dl_short = (32'(r_dshort) > 32'(MAX_DELAY)) ? PW'(MAX_DELAY) : PW'(r_dshort);
        ra       = tap_of(r_pos, dl_long);
        rb       = tap_of(r_pos, dl_short);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in     <= i_in_data;
            r_ra     <= ra;
            r_rb     <= rb;
            r_ra_fwd <= (ra == r_pos);
            r_rb_fwd <= (rb == r_pos);
            r_ra_ok  <= r_full || (ra <= r_pos);
            r_rb_ok  <= r_full || (rb <= r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_full <= 1'b0;
        end else if (out_load) begin
            if (r_pos == PW'(MAX_DELAY)) begin
                r_pos  <= '0;
                r_full <= 1'b1;
            end else begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    assign x_arr[0] = r_in.in_ch0;
    assign x_arr[1] = r_in.in_ch1;
    assign x_arr[2] = r_in.in_ch2;
    assign x_arr[3] = r_in.in_ch3;
    assign x_arr[4] = r_in.in_ch4;
    assign x_arr[5] = r_in.in_rear5;
    assign x_arr[6] = r_in.in_rear6;
    assign x_cur    = x_arr[ctrl.ch];

    assign wr_addr = {ctrl.ch, r_pos};
    assign rd_addr = {ctrl.ch, ctrl.rd_short ? r_rb : r_ra};

    always_ff @(posedge i_clk) begin
        if (ctrl.mem_wr) begin
            r_mem[wr_addr] <= x_cur;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign lp_sel = 1'(ctrl.ch - CH_W'(FIRST_REAR));
    assign lp_cur = r_lp[lp_sel];
    assign d8     = {r_d, {EXT_BITS{1'b0}}};
    assign s8     = {r_s, {EXT_BITS{1'b0}}};

    always_comb begin
        case (ctrl.mul_op)
            MUL_ALPHA: begin
                mul_a = GAIN_W'(r_alpha);
                mul_b = SUM_W'(r_diff);
            end
            MUL_SHELF: begin
                mul_a = GAIN_W'(r_sg);
                mul_b = SUM_W'(r_diff);
            end
            MUL_GAIN: begin
                mul_a = r_gain;
                mul_b = rear ? r_sum : SUM_W'(r_d);
            end
            default: begin
                mul_a = r_gain;
                mul_b = r_sum;
            end
        endcase
        mul_p = $signed({1'b0, mul_a}) * mul_b;
    end

    // Slices of the product are floor shifts; the kept bits hold the value.
    assign lp_step    = $signed(r_prod[DIFF_W+ALPHA_SHIFT-1:ALPHA_SHIFT]);
    assign shelf_term = $signed(r_prod[SUM_W+SHELF_SHIFT-1:SHELF_SHIFT]);

    always_comb begin
        if (rear) begin
            wet = MIX_W'($signed(r_prod[PROD_W-1:REAR_SHIFT]));
        end else begin
            wet = $signed(r_prod[MIX_W+FRONT_SHIFT-1:FRONT_SHIFT]);
        end
        mix_sum = MIX_W'(x_cur) + wet;
        if (!mix_sum[MIX_W-1] && (|mix_sum[MIX_W-2:SAMPLE_W-1])) begin
            mix_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (mix_sum[MIX_W-1] && !(&mix_sum[MIX_W-2:SAMPLE_W-1])) begin
            mix_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            mix_sat = mix_sum[SAMPLE_W-1:0];
        end
    end

    // A tap equal to the write position returns the sample of this frame;
    // an entry not yet written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (ctrl.cap_long) begin
            r_d <= r_ra_fwd ? x_cur : (r_ra_ok ? $signed(r_rdata) : '0);
        end
        if (ctrl.cap_short) begin
            r_s    <= r_rb_fwd ? x_cur : (r_rb_ok ? $signed(r_rdata) : '0);
            r_diff <= DIFF_W'(d8) - DIFF_W'(lp_cur);
        end
        if (ctrl.mul_en) begin
            r_prod <= mul_p;
        end
        if (ctrl.lp_upd) begin
            r_diff <= r_diff - lp_step;
        end
        if (ctrl.shelf_add) begin
            r_sum <= shelf_term + SUM_W'(lp_cur) + SUM_W'(s8);
        end
        if (ctrl.mix) begin
            r_res[ctrl.ch] <= mix_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp[0] <= '0;
            r_lp[1] <= '0;
        end else if (ctrl.lp_upd) begin
            r_lp[lp_sel] <= lp_cur + LP_W'(lp_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_ch0    <= r_res[0];
            r_out.out_ch1    <= r_res[1];
            r_out.out_ch2    <= r_res[2];
            r_out.out_ch3    <= r_res[3];
            r_out.out_ch4    <= r_res[4];
            r_out.out_rear5  <= r_res[5];
            r_out.out_rear6  <= r_res[6];
            r_out.block_done <= r_in.end_of_block;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/mddm_chk.sv */
`timescale 1ns / 1ps

module mddm_chk
    import mddm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // A frame occupies the block until its result is loaded, so no second one follows.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    // A result never appears right after a transaction is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result presented one cycle after input");

    // Loading a result returns the block to idle in the same cycle.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("block still busy when a result was loaded");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind multichannel_delay_diffusion_mixer mddm_chk u_mddm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
